/* rtl/ordered_value_list_unit_defines.svh */
// ============================================================================
// Assertion macros for the ordered value list unit
// Shared property shapes, clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef ORDERED_VALUE_LIST_UNIT_DEFINES_SVH
`define ORDERED_VALUE_LIST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OVL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ovl_pkg.sv */
// ============================================================================
// Ordered value list package
// Types, request and status codes and cell commands shared by the unit.
// ============================================================================
`timescale 1ns / 1ps

package ovl_pkg;

    localparam int OVL_DEPTH = 16;

    // Request kinds.
    localparam logic [2:0] KIND_APPEND  = 3'd0;
    localparam logic [2:0] KIND_PREPEND = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_REMOVE  = 3'd3;
    localparam logic [2:0] KIND_FIND    = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Head and tail value reported for an empty list.
    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    // Cell commands.
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_MATCH  = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_REMOVE = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [4:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_position;
        logic [4:0]         entry_count;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] value;
    } cell_cmd_t;

endpackage

/* rtl/ovl_cell.sv */
// ============================================================================
// Ordered value list cell
// Holds one entry, compares it with a broadcast value and shifts with its
// neighbours on insert and remove.
// ============================================================================
`timescale 1ns / 1ps

module ovl_cell
    import ovl_pkg::*;
#(
    parameter int DEPTH = OVL_DEPTH,
    parameter int INDEX = 0
)
(
    input  logic                             clk,
    input  cell_cmd_t                        cmd,
    input  logic [$clog2(DEPTH)-1:0]         at_pos,
    input  logic [$clog2(DEPTH+1)-1:0]       cnt,
    input  logic [31:0]                      left_entry,
    input  logic [31:0]                      right_entry,
    output logic [31:0]                      entry,
    output logic                             match
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [31:0]      entry_reg;
    logic [31:0]      entry_next;
    logic             match_reg;
    logic             match_next;
    logic [CNT_W-1:0] at_ext;

    assign at_ext = CNT_W'(at_pos);

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        unique case (cmd.act)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_MATCH:
            begin
                match_next = (entry_reg == cmd.value) && (IDX < cnt);
            end
            CELL_INSERT:
            begin
                if (IDX == at_ext)
                begin
                    entry_next = cmd.value;
                end
                else if (IDX > at_ext)
                begin
                    entry_next = left_entry;
                end
            end
            CELL_REMOVE:
            begin
                if (IDX >= at_ext)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

/* rtl/ordered_value_list_unit.sv */
// ============================================================================
// Ordered value list unit
// An ordered list of up to DEPTH signed 32-bit values kept in a row of cells.
// ============================================================================
//
//  Channel | Direction | Handshake          | Beat
//  --------+-----------+--------------------+----------------------------------
//  req     | in        | req_valid/req_stall | kind, value, position
//  rsp     | out       | rsp_valid/rsp_stall | status, found_position,
//          |           |                    | entry_count, first/last value
//
//  A request passes through the sequencer states: on acceptance every cell
//  compares its entry with the request value, in S_EXEC the lowest match is
//  located and the row of cells shifts, and in S_REPORT the result beat is loaded.
//  A new request is accepted in the cycle after the result beat is loaded.
//  A stalled result beat holds the unit in S_REPORT until the beat can
//  be loaded into the output register; a loaded beat waiting on rsp_stall does
//  not block the next request.
//  Reset empties the list; the entry cells themselves need no clearing.
//
`timescale 1ns / 1ps

module ordered_value_list_unit
    import ovl_pkg::*;
#(
    parameter int DEPTH = OVL_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Width for comparing the five-bit request position against the count.
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // Sequencer states: capture matches, update the cells, report.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_t             req_reg;
    req_t             req_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [IDX_W-1:0] hit_reg;
    logic [IDX_W-1:0] hit_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    cell_cmd_t        cmd;
    logic [IDX_W-1:0] at_pos;
    logic [31:0]      entry_vec [DEPTH];
    logic [DEPTH-1:0] match_vec;

    logic [DEPTH-1:0] lowest;
    logic             any_match;
    logic [IDX_W-1:0] hit_idx;
    logic [CMP_W-1:0] ins_pos;
    logic [CMP_W-1:0] count_ext;
    logic             accept;
    logic             load_rsp;
    logic [IDX_W-1:0] last_idx;
    logic [31:0]      hit_wide;
    logic [31:0]      count_wide;

    // ------------------------------------------------------------------
    // Row of cells. Each cell sees its neighbours' entries so that the
    // whole row shifts right on insert and left on remove, all in the same cycle.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [31:0] left_entry;
        logic [31:0] right_entry;

        if (g == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_left
            assign left_entry = entry_vec[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_right
            assign right_entry = entry_vec[g+1];
        end

        ovl_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .at_pos      (at_pos),
            .cnt         (count_reg),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_vec[g]),
            .match       (match_vec[g])
        );
    end

    // The lowest set match bit marks the first equal entry.
    assign lowest    = match_vec & (~match_vec + DEPTH'(1));
    assign any_match = |match_vec;

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (lowest[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign count_ext = CMP_W'(count_reg);

    // Position at which an addition lands.
    always_comb
    begin
        priority case (req_reg.kind)
            KIND_APPEND:  ins_pos = count_ext;
            KIND_PREPEND: ins_pos = '0;
            default:      ins_pos = CMP_W'(req_reg.position);
        endcase
    end

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign load_rsp  = (state_reg == S_REPORT) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (state_reg != S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        req_next    = req_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        cmd.act     = CELL_HOLD;
        cmd.value   = req_reg.value;
        at_pos      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    cmd.act    = CELL_MATCH;
                    cmd.value  = req.value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_DONE;
                hit_next    = '0;
                if ((req_reg.kind == KIND_APPEND) || (req_reg.kind == KIND_PREPEND) ||
                    (req_reg.kind == KIND_INSERT))
                begin
                    // The range check comes before the full check.
                    if (ins_pos > count_ext)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (count_reg == CNT_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.act    = CELL_INSERT;
                        at_pos     = ins_pos[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (req_reg.kind == KIND_REMOVE)
                begin
                    if (any_match)
                    begin
                        cmd.act    = CELL_REMOVE;
                        at_pos     = hit_idx;
                        hit_next   = hit_idx;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                else if (req_reg.kind == KIND_FIND)
                begin
                    if (any_match)
                    begin
                        hit_next = hit_idx;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result beat, built from the updated cells.
    // ------------------------------------------------------------------
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign hit_wide   = 32'(hit_reg);
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_valid_next          = rsp_valid_reg && rsp_stall;
        if (load_rsp)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.status         = status_reg;
            rsp_next.found_position = hit_wide[3:0];
            rsp_next.entry_count    = count_wide[4:0];
            if (count_reg == '0)
            begin
                rsp_next.first_value = EMPTY_VALUE;
                rsp_next.last_value  = EMPTY_VALUE;
            end
            else
            begin
                rsp_next.first_value = $signed(entry_vec[0]);
                rsp_next.last_value  = $signed(entry_vec[last_idx]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/ovl_checker.sv */
// ============================================================================
// Ordered value list checker
// Port-level assertions on the ordered value list unit, attached by bind.
// ============================================================================
`timescale 1ns / 1ps
`include "ordered_value_list_unit_defines.svh"

module ovl_checker
    import ovl_pkg::*;
#(
    parameter int DEPTH = OVL_DEPTH
)
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // Counts only fit the result field unmasked when the depth is small.
    localparam bit NARROW = (DEPTH < 32);

    logic rsp_held;
    logic req_taken;
    logic miss_beat;
    logic full_beat;
    logic empty_beat;
    logic empty_marked;

    assign rsp_held     = rsp_valid && rsp_stall;
    assign req_taken    = req_valid && !req_stall;
    assign miss_beat    = rsp_valid && (rsp.status == ST_MISS);
    assign full_beat    = rsp_valid && (rsp.status == ST_FULL) && NARROW;
    assign empty_beat   = rsp_valid && (rsp.entry_count == 5'd0) && NARROW;
    assign empty_marked = (rsp.first_value == EMPTY_VALUE) && (rsp.last_value == EMPTY_VALUE);

    // A result beat waiting on the receiver must not change.
    `OVL_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "stalled result beat changed")

    // One request at a time: the request side stalls after an acceptance.
    `OVL_ASSERT_NEXT(a_one_at_a_time, req_taken, req_stall, "request accepted while busy")

    // A miss never reports a position.
    `OVL_ASSERT_NOW(a_miss_pos, miss_beat, rsp.found_position == 4'd0, "miss with position")

    // A refusal for a full list reports a full count.
    `OVL_ASSERT_NOW(a_full_count, full_beat, rsp.entry_count == 5'(DEPTH), "full without count")

    // An empty list reports the empty mark at both ends.
    `OVL_ASSERT_NOW(a_empty_mark, empty_beat, empty_marked, "empty list without empty mark")

endmodule

bind ordered_value_list_unit ovl_checker #(.DEPTH(DEPTH)) u_ovl_checker (.*);

/* tb/testbench.sv */
// ============================================================================
// Ordered value list unit testbench
// Drives request beats through the valid/stall handshake, predicts every
// result beat from a software copy of the list and compares each field.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import ovl_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int SEGMENT_ITEMS   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_COUNT     = 5;

    // ------------------------------------------------------------------------
    // Scoreboard: a software copy of the list that computes the result beat
    // for every accepted request and holds those beats until they come out.
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [31:0] entries [OVL_DEPTH];
        int                 count;
        rsp_t               awaited_q [$];
        int                 failures;
        int                 reported;

        function new();
            count    = 0;
            failures = 0;
            reported = 0;
        endfunction

        // Every failure is counted; only the first few are printed.
        function void complain(string what);
            failures++;
            if (reported < REPORT_LIMIT)
                $display("%s", what);
            reported++;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // Puts a value at a position. The range check comes before the full
        // check, so an insert past the end of a full list reports range.
        function logic [1:0] place(int pos, logic signed [31:0] v);
            if (pos > count)
                return ST_RANGE;
            if (count >= OVL_DEPTH)
                return ST_FULL;
            for (int i = count; i > pos; i--)
                entries[i] = entries[i - 1];
            entries[pos] = v;
            count++;
            return ST_DONE;
        endfunction

        // Lowest index holding the value, or -1 when there is none.
        function int locate(logic signed [31:0] v);
            for (int i = 0; i < count; i++)
                if (entries[i] == v)
                    return i;
            return -1;
        endfunction

        function void note_request(req_t r);
            rsp_t awaited;
            int   hit;
            awaited.status         = ST_DONE;
            awaited.found_position = '0;
            case (r.kind)
                KIND_APPEND:  awaited.status = place(count, r.value);
                KIND_PREPEND: awaited.status = place(0, r.value);
                KIND_INSERT:  awaited.status = place(int'(r.position), r.value);
                KIND_REMOVE:
                begin
                    hit = locate(r.value);
                    if (hit < 0)
                        awaited.status = ST_MISS;
                    else
                    begin
                        for (int i = hit; i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        count--;
                        awaited.found_position = hit[3:0];
                    end
                end
                KIND_FIND:
                begin
                    hit = locate(r.value);
                    if (hit < 0)
                        awaited.status = ST_MISS;
                    else
                        awaited.found_position = hit[3:0];
                end
                default: ;
            endcase
            awaited.entry_count = count[4:0];
            if (count == 0)
            begin
                awaited.first_value = EMPTY_VALUE;
                awaited.last_value  = EMPTY_VALUE;
            end
            else
            begin
                awaited.first_value = entries[0];
                awaited.last_value  = entries[count - 1];
            end
            awaited_q.push_back(awaited);
        endfunction

        function void check_response(rsp_t got);
            rsp_t awaited;
            if (awaited_q.size() == 0)
            begin
                complain($sformatf("tb: result beat with nothing awaited: status %0d pos %0d count %0d first %0d last %0d",
                                   got.status, got.found_position, got.entry_count,
                                   got.first_value, got.last_value));
                return;
            end
            awaited = awaited_q.pop_front();
            if (got.status !== awaited.status
                || got.found_position !== awaited.found_position
                || got.entry_count !== awaited.entry_count
                || got.first_value !== awaited.first_value
                || got.last_value !== awaited.last_value)
                complain($sformatf({"tb: result mismatch: expected status %0d pos %0d count %0d ",
                                    "first %0d last %0d, got status %0d pos %0d count %0d ",
                                    "first %0d last %0d"},
                                   awaited.status, awaited.found_position, awaited.entry_count,
                                   awaited.first_value, awaited.last_value,
                                   got.status, got.found_position, got.entry_count,
                                   got.first_value, got.last_value));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The stimulus raises hold_requests to ask for a long hold-off; the
    // receiver process notes it in hold_served and counts the cycles itself.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    list_scoreboard scoreboard;

    ordered_value_list_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    // Receiver: random stall at the phase's rate, or a long hold-off when
    // one has been asked for. While the hold-off lasts the sender keeps
    // offering beats, so the unit fills up and has to stall its input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            rsp_stall   <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor. Values read here are those from before the edge, which is
    // what the unit itself sees, so the outcome does not hinge on the order
    // of processes within the time step.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                scoreboard.note_request(req);
            if (rsp_valid && !rsp_stall)
                scoreboard.check_response(rsp);
        end
    end

    function automatic req_t make_request(logic [2:0] kind, logic signed [31:0] value,
                                          logic [4:0] position);
        req_t r;
        r.kind     = kind;
        r.value    = value;
        r.position = position;
        return r;
    endfunction

    // Offers one request beat and returns at the edge that accepts it. The
    // valid line is only lowered when a gap follows, so a beat that runs
    // straight into the next never sees valid dropped and raised in one step.
    task automatic send_request(input req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Random request. Values come mostly from a small pool, or from the list
    // itself for removes and finds, so that hits and duplicates are common.
    // The add share is set per segment, which drives the list between empty
    // and full. A few beats carry unused kinds or out-of-range positions.
    function automatic req_t random_request(int add_pct);
        req_t r;
        int   roll;
        int   held;
        held       = scoreboard.count;
        r.position = 5'($urandom_range(31));
        roll       = $urandom_range(99);
        if (roll < 25)
            r.value = $urandom;
        else if (roll < 35)
            r.value = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        else
            r.value = $signed($urandom_range(8)) - 4;

        roll = $urandom_range(99);
        if (roll < 3)
            r.kind = 3'($urandom_range(7, 5));
        else if ($urandom_range(99) < add_pct)
        begin
            case ($urandom_range(2))
                0:       r.kind = KIND_APPEND;
                1:       r.kind = KIND_PREPEND;
                default: r.kind = KIND_INSERT;
            endcase
            if (r.kind == KIND_INSERT && $urandom_range(99) < 85)
                r.position = 5'($urandom_range(held));
        end
        else
        begin
            r.kind = ($urandom_range(99) < 60) ? KIND_REMOVE : KIND_FIND;
            if (held > 0 && $urandom_range(99) < 55)
                r.value = scoreboard.entries[$urandom_range(held - 1)];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int send_pcts [PHASE_COUNT];
        int recv_pcts [PHASE_COUNT];
        int add_pct;
        int drain;

        // Phases: no idling, sender idle, receiver stalling, both idling a
        // little, and last a long receiver hold-off with no other idling.
        send_pcts = '{0, 78, 0, 11, 0};
        recv_pcts = '{0, 0, 78, 11, 0};
        add_pct   = 50;
        scoreboard = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: misses and a refused insert on the empty list, an
        // insert into the empty list, the value extremes at both ends, an
        // insert at the end, duplicates, and the unused kinds.
        send_request(make_request(KIND_FIND, 32'sd0, 5'd0));
        send_request(make_request(KIND_REMOVE, 32'sd0, 5'd0));
        send_request(make_request(KIND_INSERT, 32'sd9, 5'd1));
        send_request(make_request(KIND_INSERT, 32'sd9, 5'd0));
        send_request(make_request(KIND_APPEND, 32'sh7fffffff, 5'd31));
        send_request(make_request(KIND_PREPEND, 32'sh80000000, 5'd0));
        send_request(make_request(KIND_INSERT, 32'sd5, 5'd3));
        send_request(make_request(KIND_INSERT, 32'sd5, 5'd1));
        send_request(make_request(KIND_FIND, 32'sd5, 5'd0));
        send_request(make_request(KIND_REMOVE, 32'sd5, 5'd0));
        send_request(make_request(KIND_FIND, 32'sd5, 5'd0));
        send_request(make_request(KIND_REMOVE, 32'sd1234, 5'd0));
        for (int k = 5; k < 8; k++)
            send_request(make_request(3'(k), -32'sd1, 5'd31));
        send_request(make_request(KIND_INSERT, -32'sd1, 5'd31));

        // Fill the list, then try every way of adding to a full list. An
        // insert past the end still reports range rather than full.
        for (int i = 0; i < 12; i++)
            send_request(make_request(KIND_APPEND, 32'(-3 * i), 5'(i)));
        send_request(make_request(KIND_APPEND, 32'sd77, 5'd0));
        send_request(make_request(KIND_PREPEND, 32'sd77, 5'd0));
        send_request(make_request(KIND_INSERT, 32'sd77, 5'd16));
        send_request(make_request(KIND_INSERT, 32'sd77, 5'd17));
        send_request(make_request(KIND_FIND, -32'sd33, 5'd0));
        send_request(make_request(KIND_REMOVE, 32'sh80000000, 5'd0));

        // Random part.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            if (phase == PHASE_COUNT - 1)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % SEGMENT_ITEMS == 0)
                begin
                    case ($urandom_range(2))
                        0:       add_pct = 85;
                        1:       add_pct = 50;
                        default: add_pct = 20;
                    endcase
                end
                send_request(random_request(add_pct));
            end
        end
        req_valid      <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Drain: wait for every awaited beat, then for the settle period as well, so
        // that a stray extra beat would still be seen.
        drain = 0;
        while (scoreboard.pending() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (scoreboard.pending() != 0)
            scoreboard.complain($sformatf("tb: %0d awaited result beats never came",
                                          scoreboard.pending()));

        if (scoreboard.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
